// ----- src/ttbc_pkg.sv -----
// ----------------------------------------------------------------------------
// ttbc_pkg: shared types and constants of the tap tempo clock
// Command codes, register indexes, field widths, reset values, the
// controller state type and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package ttbc_pkg;

    // Field widths
    localparam int CMD_W       = 3;
    localparam int TIME_W      = 32;
    localparam int BPM_IN_W    = 16;
    localparam int TEMPO_W     = 8;
    localparam int SPS_W       = 16;
    localparam int RATE_W      = 16;
    localparam int TIMEOUT_W   = 14;
    localparam int MIN_TAPS_W  = 4;
    localparam int BAR_W       = 3;
    localparam int SUB_W       = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int S_TDATA_W   = 48;
    localparam int M_TDATA_W   = 24;

    // Tap history depth default
    localparam int TAP_DEPTH_DEF = 8;

    // Arithmetic constants
    localparam int TAP_MS_PER_MIN = 60000;
    localparam int SEC_PER_MIN    = 60;

    // Tempo limits and reset values
    localparam logic [TEMPO_W-1:0]    BPM_MIN           = 8'd60;
    localparam logic [TEMPO_W-1:0]    BPM_MAX           = 8'd180;
    localparam logic [TEMPO_W-1:0]    BPM_RESET         = 8'd120;
    localparam logic [SPS_W-1:0]      SPS_RESET         = 16'd2000;
    localparam logic [RATE_W-1:0]     RATE_RESET        = 16'd16000;
    localparam logic [TIMEOUT_W-1:0]  TIMEOUT_RESET     = 14'd2000;
    localparam logic [MIN_TAPS_W-1:0] MIN_TAPS_RESET    = 4'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_TIMEOUT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TAPS    = 2'd2;

    // Input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_TICK      = 3'd0,
        CMD_TAP       = 3'd1,
        CMD_START     = 3'd2,
        CMD_STOP      = 3'd3,
        CMD_SET_TEMPO = 3'd4
    } t_cmd;

    // Controller states
    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TAP_WALK,
        S_DIV_TAP,
        S_CHK,
        S_DIV_SPS,
        S_OUT
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic load_item;
        logic exec_tick;
        logic exec_start;
        logic exec_stop;
        logic set_req_bpm;
        logic tap_record;
        logic tap_step;
        logic div_tap_start;
        logic req_from_quo;
        logic tempo_apply;
        logic sps_load;
        logic out_load;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        t_cmd cmd;
        logic walk_last;
        logic tap_ok;
        logic req_differs;
        logic div_done;
        logic out_free;
    } t_dp_stat;

    // Clamp a requested tempo to the supported range
    function automatic logic [TEMPO_W-1:0] clamp_bpm(input logic [BPM_IN_W-1:0] v);
        logic [TEMPO_W-1:0] res;
        if (v < BPM_IN_W'(BPM_MIN)) begin
            res = BPM_MIN;
        end else if (v > BPM_IN_W'(BPM_MAX)) begin
            res = BPM_MAX;
        end else begin
            res = v[TEMPO_W-1:0];
        end
        return res;
    endfunction

endpackage

// ----- src/ttbc_div.sv -----
// ----------------------------------------------------------------------------
// ttbc_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle. A start pulse loads the
// operands; a one-cycle done pulse marks a valid quotient.
// ----------------------------------------------------------------------------
module ttbc_div #(
    parameter int DVD_W = 22,
    parameter int DVS_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVS_W-1:0] r_rem;
    logic [DVD_W-1:0] r_quo;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0]   rem_sh;
    logic [DVS_W:0]   diff;
    logic             q_bit;

    // Trial subtract of the shifted remainder
    always_comb begin
        rem_sh = {r_rem, r_quo[DVD_W-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        q_bit  = ~diff[DVS_W];
    end

    // Sequencing: count the iterations, pulse done after the last
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DVD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // Operands and partial results
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= q_bit ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
            r_quo <= {r_quo[DVD_W-2:0], q_bit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider done without a running division");
`endif

endmodule

// ----- src/ttbc_ctrl.sv -----
// ----------------------------------------------------------------------------
// ttbc_ctrl: sequencing controller of the tap tempo clock
// Takes one item at a time, steps the datapath through the command's work
// (tap walk, tap division, tempo update) and hands the result to the output
// register.
// ----------------------------------------------------------------------------
module ttbc_ctrl import ttbc_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_ready,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                case (i_stat.cmd)
                    CMD_TAP:       n_state = S_TAP_WALK;
                    CMD_SET_TEMPO: n_state = S_CHK;
                    default:       n_state = S_OUT;
                endcase
            end
            S_TAP_WALK: begin
                if (i_stat.walk_last) begin
                    n_state = i_stat.tap_ok ? S_DIV_TAP : S_OUT;
                end
            end
            S_DIV_TAP: begin
                if (i_stat.div_done) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = i_stat.req_differs ? S_DIV_SPS : S_OUT;
            end
            S_DIV_SPS: begin
                if (i_stat.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready      = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            S_EXEC: begin
                case (i_stat.cmd)
                    CMD_TICK:      o_cmd.exec_tick   = 1'b1;
                    CMD_TAP:       o_cmd.tap_record  = 1'b1;
                    CMD_START:     o_cmd.exec_start  = 1'b1;
                    CMD_STOP:      o_cmd.exec_stop   = 1'b1;
                    CMD_SET_TEMPO: o_cmd.set_req_bpm = 1'b1;
                    default:       o_cmd.exec_tick   = 1'b0;
                endcase
            end
            S_TAP_WALK: begin
                o_cmd.tap_step      = 1'b1;
                o_cmd.div_tap_start = i_stat.walk_last && i_stat.tap_ok;
            end
            S_DIV_TAP: begin
                o_cmd.req_from_quo = i_stat.div_done;
            end
            S_CHK: begin
                o_cmd.tempo_apply = i_stat.req_differs;
            end
            S_DIV_SPS: begin
                o_cmd.sps_load = i_stat.div_done;
            end
            S_OUT: begin
                o_cmd.out_load = i_stat.out_free;
            end
            default: o_in_ready = 1'b0;
        endcase
    end

`ifndef SYNTHESIS
    a_div_done_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_stat.div_done |-> (r_state == S_DIV_TAP || r_state == S_DIV_SPS))
        else $error("division finished outside a division wait");

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_EXEC))
        else $error("accepted item not executed next cycle");
`endif

endmodule

// ----- src/ttbc_dp.sv -----
// ----------------------------------------------------------------------------
// ttbc_dp: datapath of the tap tempo clock
// Holds configuration, tempo and position state, the tap history shift
// line, the interval accumulator, the shared divider and the output
// register. Acts only on commands from the controller.
// ----------------------------------------------------------------------------
module ttbc_dp import ttbc_pkg::*; #(
    parameter int TAP_DEPTH = TAP_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Input item
    input  logic [CMD_W-1:0]      i_in_cmd,
    input  logic [S_TDATA_W-1:0]  i_in_data,
    // Output item
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [M_TDATA_W-1:0]  o_out_data,
    // Controller link
    input  t_dp_cmd               i_cmd,
    output t_dp_stat              o_stat
);

    localparam int K_W     = $clog2(TAP_DEPTH);
    localparam int CNT_W   = $clog2(TAP_DEPTH + 1);
    localparam int CMP_W   = (CNT_W > MIN_TAPS_W) ? CNT_W : MIN_TAPS_W;
    localparam int SUM_W   = TIMEOUT_W + K_W;
    localparam int NUM_W   = $clog2(TAP_MS_PER_MIN * TAP_DEPTH);
    localparam int SPN_W   = RATE_W + 6;
    localparam int DVD_W   = (NUM_W > SPN_W) ? NUM_W : SPN_W;
    localparam int DVS_W   = (SUM_W > TEMPO_W + 2) ? SUM_W : TEMPO_W + 2;

    // Configuration registers
    logic [RATE_W-1:0]     r_rate;
    logic [TIMEOUT_W-1:0]  r_timeout;
    logic [MIN_TAPS_W-1:0] r_min_taps;

    // Item registers
    logic [CMD_W-1:0]      r_cmd;
    logic [TIME_W-1:0]     r_time;
    logic [BPM_IN_W-1:0]   r_bpm;

    // Clock state
    logic [TEMPO_W-1:0]    r_tempo;
    logic [TEMPO_W-1:0]    r_req;
    logic                  r_run;
    logic [SPS_W-1:0]      r_sps;
    logic [SPS_W-1:0]      r_sample_cnt;
    logic [SUB_W-1:0]      r_sub;
    logic [BAR_W-1:0]      r_bar;
    logic                  r_crossed;
    logic                  r_bstart;

    // Tap state
    logic [TIME_W-1:0]     r_hist [TAP_DEPTH];
    logic [CNT_W-1:0]      r_tap_cnt;
    logic [TIME_W-1:0]     r_last_tap;
    logic [K_W-1:0]        r_k;
    logic [K_W-1:0]        r_n;
    logic [SUM_W-1:0]      r_sum;

    // Output register
    logic                  r_out_valid;
    logic [M_TDATA_W-1:0]  r_out_data;

    // Divider link
    logic                  div_start;
    logic [DVD_W-1:0]      div_dividend;
    logic [DVS_W-1:0]      div_divisor;
    logic                  div_done;
    logic [DVD_W-1:0]      div_quo;

    // Combinational helpers
    logic [SPS_W-1:0]      cnt_inc;
    logic                  crosses;
    logic [TIME_W-1:0]     gap;
    logic                  timed_out;
    logic [CNT_W-1:0]      cnt_base;
    logic [TIME_W-1:0]     iv;
    logic                  iv_used;
    logic                  tap_ok;

    // Tick arithmetic
    always_comb begin
        cnt_inc = r_sample_cnt + SPS_W'(1);
        crosses = cnt_inc >= r_sps;
    end

    // Tap arithmetic
    always_comb begin
        gap       = r_time - r_last_tap;
        timed_out = gap > TIME_W'(r_timeout);
        cnt_base  = timed_out ? '0 : r_tap_cnt;
        iv        = r_hist[0] - r_hist[1];
        iv_used   = ((CNT_W'(r_k) + CNT_W'(1)) < r_tap_cnt)
                    && (iv != '0) && (iv < TIME_W'(r_timeout));
        tap_ok    = !(CMP_W'(r_tap_cnt) < CMP_W'(r_min_taps)) && (r_n != '0);
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate     <= RATE_RESET;
            r_timeout  <= TIMEOUT_RESET;
            r_min_taps <= MIN_TAPS_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                REG_SAMPLE_RATE: r_rate     <= i_cfg_data[RATE_W-1:0];
                REG_TAP_TIMEOUT: r_timeout  <= i_cfg_data[TIMEOUT_W-1:0];
                REG_MIN_TAPS:    r_min_taps <= i_cfg_data[MIN_TAPS_W-1:0];
                default:         r_rate     <= r_rate;
            endcase
        end
    end

    // Capture the accepted item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_cmd  <= i_in_cmd;
            r_time <= i_in_data[TIME_W-1:0];
            r_bpm  <= i_in_data[TIME_W +: BPM_IN_W];
        end
    end

    // Tempo request
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_req_bpm) begin
            r_req <= clamp_bpm(r_bpm);
        end else if (i_cmd.req_from_quo) begin
            r_req <= clamp_bpm(div_quo[BPM_IN_W-1:0]);
        end
    end

    // Run flag, tempo, phase and position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tempo      <= BPM_RESET;
            r_run        <= 1'b0;
            r_sps        <= SPS_RESET;
            r_sample_cnt <= '0;
            r_sub        <= '0;
            r_bar        <= '0;
            r_crossed    <= 1'b0;
            r_bstart     <= 1'b0;
        end else begin
            if (i_cmd.load_item) begin
                r_crossed <= 1'b0;
                r_bstart  <= 1'b0;
            end
            if (i_cmd.exec_tick && r_run) begin
                if (crosses) begin
                    r_sample_cnt <= cnt_inc - r_sps;
                    r_crossed    <= 1'b1;
                    r_sub        <= r_sub + SUB_W'(1);
                    if (r_sub == '1) begin
                        r_bar    <= r_bar + BAR_W'(1);
                        r_bstart <= 1'b1;
                    end
                end else begin
                    r_sample_cnt <= cnt_inc;
                end
            end
            if (i_cmd.exec_start) begin
                r_run        <= 1'b1;
                r_sample_cnt <= '0;
            end
            if (i_cmd.exec_stop) begin
                r_run <= 1'b0;
            end
            if (i_cmd.tempo_apply) begin
                r_tempo <= r_req;
            end
            if (i_cmd.sps_load) begin
                r_sps        <= div_quo[SPS_W-1:0];
                r_sample_cnt <= '0;
            end
        end
    end

    // Tap count, last tap and interval accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_cnt  <= '0;
            r_last_tap <= '0;
            r_k        <= '0;
            r_n        <= '0;
            r_sum      <= '0;
        end else if (i_cmd.tap_record) begin
            r_tap_cnt  <= (cnt_base < CNT_W'(TAP_DEPTH)) ? cnt_base + CNT_W'(1) : cnt_base;
            r_last_tap <= r_time;
            r_k        <= '0;
            r_n        <= '0;
            r_sum      <= '0;
        end else if (i_cmd.tap_step) begin
            r_k <= r_k + K_W'(1);
            if (iv_used) begin
                r_n   <= r_n + K_W'(1);
                r_sum <= r_sum + SUM_W'(iv[TIMEOUT_W-1:0]);
            end
        end
    end

    // History: shift a new tap in, rotate one place per walk step
    always_ff @(posedge i_clk) begin
        if (i_cmd.tap_record) begin
            r_hist[0] <= r_time;
            for (int i = 1; i < TAP_DEPTH; i++) begin
                r_hist[i] <= r_hist[i-1];
            end
        end else if (i_cmd.tap_step) begin
            for (int i = 0; i < TAP_DEPTH - 1; i++) begin
                r_hist[i] <= r_hist[i+1];
            end
            r_hist[TAP_DEPTH-1] <= r_hist[0];
        end
    end

    // Divider operands: tap tempo or samples per sixteenth
    always_comb begin
        div_start = i_cmd.div_tap_start | i_cmd.tempo_apply;
        if (i_cmd.tempo_apply) begin
            div_dividend = DVD_W'(r_rate) * DVD_W'(SEC_PER_MIN);
            div_divisor  = DVS_W'({r_req, 2'b00});
        end else begin
            div_dividend = DVD_W'(r_n) * DVD_W'(TAP_MS_PER_MIN);
            div_divisor  = DVS_W'(r_sum);
        end
    end

    ttbc_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    // Output register: hold until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_data <= {4'b0000, r_run, r_tempo, r_sub, r_sub[3:2],
                           r_bar, r_bstart, r_crossed};
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Status to the controller
    always_comb begin
        o_stat.cmd         = t_cmd'(r_cmd);
        o_stat.walk_last   = (r_k == K_W'(TAP_DEPTH - 1));
        o_stat.tap_ok      = tap_ok;
        o_stat.req_differs = (r_req != r_tempo);
        o_stat.div_done    = div_done;
        o_stat.out_free    = !r_out_valid || i_out_ready;
    end

`ifndef SYNTHESIS
    a_tap_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tap_cnt <= CNT_W'(TAP_DEPTH))
        else $error("tap count beyond history depth");

    a_tempo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tempo >= BPM_MIN) && (r_tempo <= BPM_MAX))
        else $error("tempo outside the supported range");
`endif

endmodule

// ----- src/tap_tempo_bpm_clock_top.sv -----
// Tap tempo clock. One result item leaves for every input item, in order.
// Items are taken one at a time. From the cycle in which an item is
// accepted, the controller steps through its states up to the one that
// loads its result into the output register:
// - A tick, start, stop or unknown command goes through execute and output.
// - A set-tempo command goes through execute, the tempo check and output.
//   When the tempo really changes, the shared bit-serial divider works out
//   its 22 quotient bits, one bit per cycle, before its done flag ends the wait.
// - A tap goes through the record and the walk over the history. When a
//   tempo is derived it adds the interval division and the tempo check.
//   When that tempo differs it adds the samples-per-sixteenth update.
// The next item is accepted in the cycle after the previous one has reached
// the output register. A result that is not taken holds the controller, and
// with it the input.
// ----------------------------------------------------------------------------
// tap_tempo_bpm_clock_top: top level of the tap tempo clock
// Stream input of commands, stream output of clock status, plain
// configuration write port. Joins the controller and the datapath.
// ----------------------------------------------------------------------------
module tap_tempo_bpm_clock_top import ttbc_pkg::*; #(
    parameter int TAP_DEPTH = TAP_DEPTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // Command stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // tap_time_ms[31:0], new_bpm[47:32]
    input  logic [CMD_W-1:0]      s_axis_tuser,  // cmd[2:0]
    // Status stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [M_TDATA_W-1:0]  m_axis_tdata   // sub_crossed[0], bar_start[1],
                                                 // bar_pos[4:2], beat_pos[6:5],
                                                 // sub_pos[10:7], tempo_bpm[18:11],
                                                 // is_running[19], zero[23:20]
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    ttbc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    ttbc_dp #(
        .TAP_DEPTH (TAP_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_cmd    (s_axis_tuser),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat)
    );

endmodule

// ----- tb/tap_tempo_bpm_clock_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tap_tempo_bpm_clock_top_tb: self-checking bench for the tap tempo clock
// Streams tick, tap, start, stop, set-tempo and unused commands into the
// block under bursty traffic and a stalling receiver. A local model of the
// clock predicts every status item, which is checked field by field in order.
// Register settings are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tap_tempo_bpm_clock_top_tb;
    import ttbc_pkg::*;

    localparam int HIST_DEPTH          = TAP_DEPTH_DEF;
    localparam int SIXTEENTHS_PER_BEAT = 4;
    localparam int ITEMS_PER_PHASE     = 128;
    localparam int SETTLE_CYCLES       = 120;
    localparam int LONG_HOLD_CYCLES    = 400;
    localparam int MAX_PRINTED         = 40;
    localparam longint CYCLE_LIMIT     = 1000000;

    // Command codes the block must ignore
    localparam logic [CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;
    // Register index with no register behind it
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    typedef struct {
        logic [CMD_W-1:0]    cmd;
        logic [TIME_W-1:0]   tap_time;
        logic [BPM_IN_W-1:0] new_bpm;
    } t_tempo_cmd;

    typedef struct {
        logic               crossed;
        logic               bar_start;
        logic [BAR_W-1:0]   bar;
        logic [1:0]         beat;
        logic [SUB_W-1:0]   sub;
        logic [TEMPO_W-1:0] tempo;
        logic               running;
    } t_clock_status;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx     = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;  // tap_time_ms[31:0], new_bpm[47:32]
    logic [CMD_W-1:0]      s_axis_tuser  = '0;  // cmd[2:0]
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;        // sub_crossed[0], bar_start[1],
                                                // bar_pos[4:2], beat_pos[6:5],
                                                // sub_pos[10:7], tempo_bpm[18:11],
                                                // is_running[19], zero[23:20]

    tap_tempo_bpm_clock_top #(.TAP_DEPTH(HIST_DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Register copies
    logic [RATE_W-1:0]     cfg_rate     = RATE_RESET;
    logic [TIMEOUT_W-1:0]  cfg_timeout  = TIMEOUT_RESET;
    logic [MIN_TAPS_W-1:0] cfg_min_taps = MIN_TAPS_RESET;

    // Clock model state
    logic [TEMPO_W-1:0] mdl_tempo     = BPM_RESET;
    logic               mdl_running   = 1'b0;
    logic [SPS_W-1:0]   mdl_sps       = SPS_RESET;
    logic [SPS_W-1:0]   mdl_phase     = '0;
    logic [SUB_W-1:0]   mdl_sixteenth = '0;
    logic [BAR_W-1:0]   mdl_bar       = '0;
    logic [TIME_W-1:0]  mdl_taps [HIST_DEPTH] = '{default: '0};
    logic [3:0]         mdl_tap_cnt   = '0;
    logic [TIME_W-1:0]  mdl_last_tap  = '0;

    t_tempo_cmd    pending_cmds[$];
    t_clock_status expected_status[$];
    t_tempo_cmd    cur_cmd;

    int     burst_left = 0;
    int     gap_left = 0;
    int     hold_left = 0;
    int     rx_seg_left = 0;
    logic [7:0] rx_pattern = 8'hFF;
    int     items_accepted = 0;
    int     results_seen = 0;
    int     mismatch_count = 0;
    int     crossings = 0;
    int     bar_starts = 0;
    int     tap_retunes = 0;
    int     settings_applied = 1;
    bit     gen_running = 1'b0;
    longint cycle_count = 0;

    // Clamp a requested tempo and retune the sixteenth length on a real change
    function automatic void retune(input logic [BPM_IN_W-1:0] req);
        logic [TEMPO_W-1:0] t;
        logic [31:0]        div;
        if (req < BPM_IN_W'(BPM_MIN)) t = BPM_MIN;
        else if (req > BPM_IN_W'(BPM_MAX)) t = BPM_MAX;
        else t = req[TEMPO_W-1:0];
        if (t != mdl_tempo) begin
            mdl_tempo = t;
            div = (32'(cfg_rate) * SEC_PER_MIN) / (32'(t) * SIXTEENTHS_PER_BEAT);
            mdl_sps = div[SPS_W-1:0];
            mdl_phase = '0;
        end
    endfunction

    // Record a tap and derive a tempo from the stored intervals
    function automatic void record_tap(input logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] iv;
        logic [31:0]       iv_sum;
        logic [31:0]       iv_num;
        logic [63:0]       quo;
        iv_sum = 0;
        iv_num = 0;
        if (now - mdl_last_tap > 32'(cfg_timeout)) mdl_tap_cnt = '0;
        mdl_last_tap = now;
        for (int i = HIST_DEPTH - 1; i > 0; i--) mdl_taps[i] = mdl_taps[i-1];
        mdl_taps[0] = now;
        if (mdl_tap_cnt < HIST_DEPTH) mdl_tap_cnt++;
        if (mdl_tap_cnt < cfg_min_taps) return;
        for (int i = 0; i + 1 < mdl_tap_cnt; i++) begin
            iv = mdl_taps[i] - mdl_taps[i+1];
            if (iv > 0 && iv < 32'(cfg_timeout)) begin
                iv_sum += iv;
                iv_num++;
            end
        end
        if (iv_num > 0 && iv_sum > 0) begin
            quo = (64'(TAP_MS_PER_MIN) * iv_num) / iv_sum;
            if (quo > 64'hFFFF) quo = 64'hFFFF;
            retune(quo[BPM_IN_W-1:0]);
        end
    endfunction

    // Advance the clock model by one command and return the status it reports
    function automatic t_clock_status step_tempo_clock(input t_tempo_cmd c);
        t_clock_status st;
        logic [TEMPO_W-1:0] old_tempo;
        st.crossed = 1'b0;
        st.bar_start = 1'b0;
        case (c.cmd)
            CMD_TICK: begin
                if (mdl_running) begin
                    mdl_phase = mdl_phase + 1'b1;
                    if (mdl_phase >= mdl_sps) begin
                        mdl_phase = mdl_phase - mdl_sps;
                        st.crossed = 1'b1;
                        mdl_sixteenth = mdl_sixteenth + 1'b1;
                        if (mdl_sixteenth == 0) begin
                            mdl_bar = mdl_bar + 1'b1;
                            st.bar_start = 1'b1;
                        end
                    end
                end
            end
            CMD_TAP: begin
                old_tempo = mdl_tempo;
                record_tap(c.tap_time);
                if (mdl_tempo != old_tempo) tap_retunes++;
            end
            CMD_START: begin
                mdl_running = 1'b1;
                mdl_phase = '0;
            end
            CMD_STOP: mdl_running = 1'b0;
            CMD_SET_TEMPO: retune(c.new_bpm);
            default: ;
        endcase
        st.bar = mdl_bar;
        st.beat = mdl_sixteenth[SUB_W-1:2];
        st.sub = mdl_sixteenth;
        st.tempo = mdl_tempo;
        st.running = mdl_running;
        return st;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] result %0d: %s got %0d want %0d",
                     $realtime, results_seen, what, got, want);
        mismatch_count++;
    endtask

    task automatic compare_field(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    // Present queued items in bursts with random gaps; predict on acceptance
    always @(posedge i_clk) begin : drive_cmds
        logic offer;
        offer = 1'b0;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_status.push_back(step_tempo_clock(cur_cmd));
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_cmds.size() > 0) begin
                    cur_cmd = pending_cmds.pop_front();
                    offer = 1'b1;
                    if (burst_left > 0) burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 70);
                    end
                end
                s_axis_tvalid <= offer;
                s_axis_tdata <= {cur_cmd.new_bpm, cur_cmd.tap_time};
                s_axis_tuser <= cur_cmd.cmd;
            end
        end
    end

    // Take status items against the predicted ones; stall on a rolling pattern
    always @(posedge i_clk) begin : watch_status
        t_clock_status got;
        t_clock_status want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.crossed = m_axis_tdata[0];
                got.bar_start = m_axis_tdata[1];
                got.bar = m_axis_tdata[4:2];
                got.beat = m_axis_tdata[6:5];
                got.sub = m_axis_tdata[10:7];
                got.tempo = m_axis_tdata[18:11];
                got.running = m_axis_tdata[19];
                if (expected_status.size() == 0) begin
                    report_mismatch("unexpected item, tdata", 32'(m_axis_tdata), 0);
                end else begin
                    want = expected_status.pop_front();
                    if (want.crossed) crossings++;
                    if (want.bar_start) bar_starts++;
                    compare_field("sub_crossed", got.crossed, want.crossed);
                    compare_field("bar_start", got.bar_start, want.bar_start);
                    compare_field("bar_pos", got.bar, want.bar);
                    compare_field("beat_pos", got.beat, want.beat);
                    compare_field("sub_pos", got.sub, want.sub);
                    compare_field("tempo_bpm", got.tempo, want.tempo);
                    compare_field("is_running", got.running, want.running);
                    compare_field("padding", m_axis_tdata[23:20], 0);
                end
                results_seen++;
                // hold off long enough for the block to back up into its input
                if (results_seen == 300 || results_seen == 800) hold_left = LONG_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (rx_seg_left == 0) begin
                    case ($urandom_range(0, 3))
                        0: rx_pattern = 8'hFF;
                        1: rx_pattern = 8'h01;
                        default: rx_pattern = 8'($urandom);
                    endcase
                    rx_seg_left = $urandom_range(8, 64);
                end
                rx_seg_left--;
                m_axis_tready <= rx_pattern[0];
                rx_pattern = {rx_pattern[0], rx_pattern[7:1]};
            end
        end
    end

    always @(posedge i_clk) cycle_count <= cycle_count + 1;

    initial begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("run stopped by cycle limit with %0d items still expected",
                 expected_status.size());
        $display("FAILURE");
        $finish;
    end

    task automatic push_cmd(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] t,
                            input logic [BPM_IN_W-1:0] bpm);
        t_tempo_cmd c;
        c.cmd = cmd;
        c.tap_time = t;
        c.new_bpm = bpm;
        pending_cmds.push_back(c);
    endtask

    // Push a run of taps at a steady interval, with the odd wild gap or double tap
    task automatic push_tap_run(input int taps);
        logic [TIME_W-1:0] t;
        logic [TIME_W-1:0] iv_base;
        logic [TIME_W-1:0] iv;
        t = $urandom;
        iv_base = $urandom_range(200, 1200);
        if (cfg_timeout > 2 && iv_base >= cfg_timeout)
            iv_base = $urandom_range(1, cfg_timeout - 1);
        repeat (taps) begin
            push_cmd(CMD_TAP, t, 16'($urandom));
            case ($urandom_range(0, 15))
                0: iv = $urandom;
                1: iv = '0;
                default: iv = iv_base + $urandom_range(0, iv_base / 8);
            endcase
            t = t + iv;
        end
    endtask

    // Mostly running tick streams, with taps, tempo changes and noise mixed in
    task automatic push_random_items(input int count);
        int pushed;
        int pick;
        int k;
        logic [BPM_IN_W-1:0] bpm;
        pushed = 0;
        while (pushed < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                if (!gen_running && $urandom_range(0, 3) != 0) begin
                    push_cmd(CMD_START, $urandom, 16'($urandom));
                    gen_running = 1'b1;
                    pushed++;
                end
                k = $urandom_range(1, 20);
                repeat (k) push_cmd(CMD_TICK, $urandom, 16'($urandom));
                pushed += k;
            end else if (pick < 70) begin
                k = $urandom_range(1, 10);
                push_tap_run(k);
                pushed += k;
            end else if (pick < 76) begin
                push_cmd(CMD_START, $urandom, 16'($urandom));
                gen_running = 1'b1;
                pushed++;
            end else if (pick < 80) begin
                push_cmd(CMD_STOP, $urandom, 16'($urandom));
                gen_running = 1'b0;
                pushed++;
            end else if (pick < 92) begin
                bpm = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(40, 200));
                push_cmd(CMD_SET_TEMPO, $urandom, bpm);
                pushed++;
            end else begin
                push_cmd(3'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST)), $urandom,
                         16'($urandom));
                pushed++;
            end
        end
    endtask

    // Wait until every item is in and out, then let the block go quiet
    task automatic settle_block();
        while (pending_cmds.size() > 0 || s_axis_tvalid || expected_status.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_cfg_reg(input logic [CFG_IDX_W-1:0] idx,
                                 input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        case (idx)
            REG_SAMPLE_RATE: cfg_rate = data;
            REG_TAP_TIMEOUT: cfg_timeout = data[TIMEOUT_W-1:0];
            REG_MIN_TAPS:    cfg_min_taps = data[MIN_TAPS_W-1:0];
            default: ;
        endcase
    endtask

    // Settle, load a new register set, then queue a phase of random items
    task automatic run_phase(input logic [CFG_DATA_W-1:0] rate,
                             input logic [CFG_DATA_W-1:0] timeout,
                             input logic [CFG_DATA_W-1:0] min_taps);
        settle_block();
        write_cfg_reg(REG_SAMPLE_RATE, rate);
        write_cfg_reg(REG_TAP_TIMEOUT, timeout);
        write_cfg_reg(REG_MIN_TAPS, min_taps);
        if ($urandom_range(0, 1) == 1) write_cfg_reg(REG_UNUSED, 16'($urandom));
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        settings_applied++;
        push_random_items(ITEMS_PER_PHASE);
    endtask

    initial begin : main_seq
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: ignored commands, stopped clock, tempo clamps, tap corners
        for (int c = CMD_RSVD_FIRST; c <= CMD_RSVD_LAST; c++)
            push_cmd(3'(c), 32'hFFFF_FFFF, 16'hFFFF);
        push_cmd(CMD_TICK, '0, '0);
        push_cmd(CMD_STOP, $urandom, 16'($urandom));
        push_cmd(CMD_SET_TEMPO, $urandom, 16'd0);
        push_cmd(CMD_SET_TEMPO, $urandom, 16'hFFFF);
        push_cmd(CMD_SET_TEMPO, $urandom, 16'd180);
        push_cmd(CMD_SET_TEMPO, $urandom, 16'd59);
        push_cmd(CMD_SET_TEMPO, $urandom, 16'd181);
        push_cmd(CMD_SET_TEMPO, $urandom, 16'd120);
        push_cmd(CMD_START, $urandom, 16'($urandom));
        push_cmd(CMD_TICK, $urandom, 16'($urandom));
        push_cmd(CMD_TICK, $urandom, 16'($urandom));
        // steady taps across the time wrap, then a long gap, then double taps
        push_cmd(CMD_TAP, 32'hFFFF_FE00, '0);
        push_cmd(CMD_TAP, 32'hFFFF_FF90, '0);
        push_cmd(CMD_TAP, 32'h0000_0120, '0);
        push_cmd(CMD_TAP, 32'h0000_14A8, '0);
        push_cmd(CMD_TAP, 32'h0000_14A8, '0);
        push_cmd(CMD_TAP, 32'h0000_14A8, '0);
        push_cmd(CMD_SET_TEMPO, $urandom, 16'd60);
        push_cmd(CMD_STOP, $urandom, 16'($urandom));
        push_cmd(CMD_TICK, $urandom, 16'($urandom));
        push_cmd(CMD_START, $urandom, 16'($urandom));
        gen_running = 1'b1;
        push_random_items(ITEMS_PER_PHASE);

        // Register sets: zero rate, masked-in extremes, saturating and
        // disabled tap thresholds, zero timeout
        run_phase(16'd0, 16'hFFFF, 16'hFFF0);
        run_phase(16'd24, 16'd100, 16'd2);
        run_phase(16'd240, 16'd10000, 16'd8);
        run_phase(16'hFFFF, 16'd2000, 16'd1);
        run_phase(16'd48000, 16'd3000, 16'd15);
        run_phase(16'd8000, 16'd0, 16'd4);
        run_phase(16'd120, 16'd1500, 16'd3);
        settle_block();

        if (expected_status.size() > 0)
            report_mismatch("items never delivered", expected_status.size(), 0);
        $display("run covered %0d commands over %0d register settings",
                 items_accepted, settings_applied);
        $display("saw %0d sixteenth crossings, %0d bar starts, %0d tempo changes from taps",
                 crossings, bar_starts, tap_retunes);
        if (mismatch_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
